// ===== rtl/gnps_pkg.sv =====
// Shared types and constants for the grid nearest point search block.
// Depends on nothing; imported by grid_nearest_point_search.
package gnps_pkg;

   localparam int COORD_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int DIST_W   = 40;
   localparam int SQ_W     = 64;
   localparam int DEN_W    = 65;
   localparam int CSR_IDX_W = 3;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_TARGET_X  = 3'd0;
   localparam csr_index_type CSR_TARGET_Y  = 3'd1;
   localparam csr_index_type CSR_ROW_COUNT = 3'd2;
   localparam csr_index_type CSR_COL_COUNT = 3'd3;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_DEGENERATE = 1'b1;

endpackage

// ===== rtl/grid_nearest_point_search.sv =====
// Grid nearest point search: top level with grid stores, step setup and scan.
// Depends on gnps_pkg.
//
// Usage:
//   req_* : one grid cell per transfer, row-major. tdata holds grid_x (low
//           word) and grid_y (high word); tlast marks the final cell and
//           starts the search. Each cell is written at a running index that
//           wraps at MAX_ROWS*MAX_COLS and returns to zero after tlast.
//   rsp_* : one result per tlast cell: best_row, best_col (1-based) and the
//           normalised squared distance in Q24.16; tuser carries the status
//           (1 = degenerate grid, all other fields zero).
//   csr_* : register writes (target_x, target_y, row_count, col_count),
//           always ready; only while the block is idle.
// Sequence: a plain cell is taken whenever the block is idle. After tlast the
//   block reads the three step cells, then scans rows*cols cells, each with
//   one store read, magnitude and square stages, then two restoring dividers
//   in parallel that retire one quotient bit per cycle. req_tready is low
//   during the search.
// Reset (synchronous, active high) clears the control registers to their reset
//   values and drops any pending result; the stores are not cleared.
// A stalled receiver holds the result in the output register; loading
//   continues, and a further search runs but holds its result until the previous one is taken.
module grid_nearest_point_search #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,  // grid_x[31:0], grid_y[63:32]
   input  logic                               req_tlast,  // last_cell
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [55:0]                        rsp_tdata,  // best_row[6:0], best_col[13:7],
                                                          // min_distance[53:14], zero[55:54]
   output logic                               rsp_tuser,  // status
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  gnps_pkg::csr_index_type            csr_index,
   input  logic [gnps_pkg::COORD_W-1:0]       csr_data
);
   import gnps_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_B0   = 4'd1;
   localparam logic [3:0] S_B1   = 4'd2;
   localparam logic [3:0] S_B2   = 4'd3;
   localparam logic [3:0] S_B3   = 4'd4;
   localparam logic [3:0] S_B4   = 4'd5;
   localparam logic [3:0] S_B5   = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_RD   = 4'd8;
   localparam logic [3:0] S_W1   = 4'd9;
   localparam logic [3:0] S_W2   = 4'd10;
   localparam logic [3:0] S_INIT = 4'd11;
   localparam logic [3:0] S_DIV  = 4'd12;
   localparam logic [3:0] S_CMP  = 4'd13;
   localparam logic [3:0] S_DONE = 4'd14;

   // configuration
   logic [COORD_W-1:0] target_ff [2];
   logic [COUNT_W-1:0] row_count_ff, col_count_ff;

   // control
   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      windex_ff;
   logic [AW-1:0]      cell_ff;
   logic [COUNT_W-1:0] rows_ff, cols_ff, row_ff, col_ff;
   logic [COUNT_W-1:0] rows_in, cols_in;
   logic               deg_ff;
   logic [5:0]         div_cnt_ff;
   logic               rsp_valid_ff;

   // stores and datapath
   logic [COORD_W-1:0] x_mem [DEPTH];
   logic [COORD_W-1:0] y_mem [DEPTH];
   logic [AW-1:0]      rd_addr;
   logic [COORD_W-1:0] rdata_ff [2];
   logic [COORD_W-1:0] base_ff  [2];
   logic [COORD_W-1:0] mag_ff   [2];
   logic [COORD_W-1:0] mag_in   [2];
   logic [SQ_W-1:0]    sq_ff    [2];
   logic [DEN_W-1:0]   den_ff   [2];
   logic [DEN_W-1:0]   rem_ff   [2];
   logic [DEN_W-1:0]   rem_in   [2];
   logic               qbit_in  [2];
   logic [DIST_W-1:0]  lo_ff    [2];
   logic [DIST_W-1:0]  quo_ff   [2];
   logic               sat_ff   [2];
   logic [DIST_W-1:0]  term     [2];
   logic [DIST_W:0]    total_wide;
   logic [DIST_W-1:0]  total;
   logic [DIST_W-1:0]  best_dist_ff;
   logic [COUNT_W-1:0] best_row_ff, best_col_ff;
   logic [55:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic accept, use_base, last_scan_cell, can_load;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign can_load   = !rsp_valid_ff || rsp_tready;

   // clamp the counts: above the maximum saturates, zero counts as one
   always_comb begin
      if ({25'd0, row_count_ff} > 32'(MAX_ROWS)) rows_in = COUNT_W'(MAX_ROWS);
      else if (row_count_ff == '0)                rows_in = COUNT_W'(1);
      else                                        rows_in = row_count_ff;
      if ({25'd0, col_count_ff} > 32'(MAX_COLS)) cols_in = COUNT_W'(MAX_COLS);
      else if (col_count_ff == '0)                cols_in = COUNT_W'(1);
      else                                        cols_in = col_count_ff;
   end

   // store read address: step cells first, then the scan index
   always_comb begin
      unique case (state_ff)
         S_B0:    rd_addr = '0;
         S_B1:    rd_addr = AW'(1);
         S_B2:    rd_addr = AW'(cols_ff);
         default: rd_addr = cell_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_mem[windex_ff] <= req_tdata[31:0];
         y_mem[windex_ff] <= req_tdata[63:32];
      end
      rdata_ff[0] <= x_mem[rd_addr];
      rdata_ff[1] <= y_mem[rd_addr];
   end

   // axis error magnitude: against cell(0,0) while finding the step,
   // against the target while scanning
   assign use_base = (state_ff == S_B2) || (state_ff == S_B3);

   always_comb begin
      logic [COORD_W-1:0] other;
      logic [COORD_W:0]   diff;
      for (int l = 0; l < 2; l++) begin
         other = use_base ? base_ff[l] : target_ff[l];
         diff  = {rdata_ff[l][COORD_W-1], rdata_ff[l]} - {other[COORD_W-1], other};
         mag_in[l] = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      end
   end

   // restoring divider step, one quotient bit per cycle
   always_comb begin
      logic [DEN_W:0] trial;
      for (int l = 0; l < 2; l++) begin
         trial      = {rem_ff[l], lo_ff[l][DIST_W-1]};
         qbit_in[l] = (trial >= {1'b0, den_ff[l]});
         rem_in[l]  = qbit_in[l] ? DEN_W'(trial - {1'b0, den_ff[l]}) : trial[DEN_W-1:0];
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) term[l] = sat_ff[l] ? DIST_MAX : quo_ff[l];
      total_wide = {1'b0, term[0]} + {1'b0, term[1]};
      total      = total_wide[DIST_W] ? DIST_MAX : total_wide[DIST_W-1:0];
   end

   assign last_scan_cell = (row_ff == rows_ff - COUNT_W'(1)) &&
                           (col_ff == cols_ff - COUNT_W'(1));

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_tlast) begin
               if (rows_in < COUNT_W'(2) || cols_in < COUNT_W'(2)) state_in = S_DONE;
               else                                                state_in = S_B0;
            end
         end
         S_B0:   state_in = S_B1;
         S_B1:   state_in = S_B2;
         S_B2:   state_in = S_B3;
         S_B3:   state_in = S_B4;
         S_B4:   state_in = S_B5;
         S_B5:   state_in = S_CHK;
         S_CHK:  state_in = (den_ff[0] == '0 || den_ff[1] == '0) ? S_DONE : S_RD;
         S_RD:   state_in = S_W1;
         S_W1:   state_in = S_W2;
         S_W2:   state_in = S_INIT;
         S_INIT: state_in = S_DIV;
         S_DIV:  state_in = (div_cnt_ff == 6'd1) ? S_CMP : S_DIV;
         S_CMP:  state_in = last_scan_cell ? S_DONE : S_RD;
         S_DONE: state_in = can_load ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         windex_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff[0] <= '0;
         target_ff[1] <= '0;
         row_count_ff <= COUNT_W'(64);
         col_count_ff <= COUNT_W'(64);
         deg_ff       <= 1'b0;
         best_dist_ff <= DIST_MAX;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TARGET_X:  target_ff[0] <= csr_data;
               CSR_TARGET_Y:  target_ff[1] <= csr_data;
               CSR_ROW_COUNT: row_count_ff <= csr_data[COUNT_W-1:0];
               CSR_COL_COUNT: col_count_ff <= csr_data[COUNT_W-1:0];
               default: ;   // drop writes beyond the register list
            endcase
         end

         // advance the load index; return to zero after the last cell
         if (accept) begin
            if (req_tlast || windex_ff == AW'(DEPTH - 1)) windex_ff <= '0;
            else                                           windex_ff <= windex_ff + AW'(1);
         end

         if (state_ff == S_IDLE && accept && req_tlast) begin
            deg_ff       <= (rows_in < COUNT_W'(2) || cols_in < COUNT_W'(2));
            best_dist_ff <= DIST_MAX;
            best_row_ff  <= '0;
            best_col_ff  <= '0;
         end
         if (state_ff == S_CHK && (den_ff[0] == '0 || den_ff[1] == '0)) deg_ff <= 1'b1;

         // keep the first strictly smallest distance
         if (state_ff == S_CMP && total < best_dist_ff) begin
            best_dist_ff <= total;
            best_row_ff  <= row_ff;
            best_col_ff  <= col_ff;
         end

         // load a new result, else drop the one just taken
         if (state_ff == S_DONE && can_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept && req_tlast) begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end

      for (int l = 0; l < 2; l++) begin
         mag_ff[l] <= mag_in[l];
         sq_ff[l]  <= {32'd0, mag_ff[l]} * {32'd0, mag_ff[l]};
         if (state_ff == S_B1) base_ff[l] <= rdata_ff[l];
         // squared step: sum of the two neighbour squares
         if (state_ff == S_B4) den_ff[l] <= DEN_W'(sq_ff[l]);
         if (state_ff == S_B5) den_ff[l] <= den_ff[l] + DEN_W'(sq_ff[l]);
         if (state_ff == S_INIT) begin
            sat_ff[l] <= ({25'd0, sq_ff[l][SQ_W-1:24]} >= den_ff[l]);
            rem_ff[l] <= {25'd0, sq_ff[l][SQ_W-1:24]};
            lo_ff[l]  <= {sq_ff[l][23:0], 16'd0};
            quo_ff[l] <= '0;
         end
         if (state_ff == S_DIV) begin
            rem_ff[l] <= rem_in[l];
            lo_ff[l]  <= {lo_ff[l][DIST_W-2:0], 1'b0};
            quo_ff[l] <= {quo_ff[l][DIST_W-2:0], qbit_in[l]};
         end
      end

      if (state_ff == S_INIT) div_cnt_ff <= 6'd40;
      else if (state_ff == S_DIV) div_cnt_ff <= div_cnt_ff - 6'd1;

      if (state_ff == S_CHK) begin
         cell_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (state_ff == S_CMP) begin
         cell_ff <= cell_ff + AW'(1);
         if (col_ff == cols_ff - COUNT_W'(1)) begin
            col_ff <= '0;
            row_ff <= row_ff + COUNT_W'(1);
         end else begin
            col_ff <= col_ff + COUNT_W'(1);
         end
      end

      if (state_ff == S_DONE && can_load) begin
         if (deg_ff) begin
            rsp_data_ff <= '0;
            rsp_user_ff <= STATUS_DEGENERATE;
         end else begin
            rsp_data_ff <= {2'b00, best_dist_ff,
                            best_col_ff + COUNT_W'(1), best_row_ff + COUNT_W'(1)};
            rsp_user_ff <= STATUS_OK;
         end
      end
   end

endmodule
